>>> rtl/tmb_pkg.sv
// Package for the one-shot timer bank: item types, command and result codes,
// and the control structs passed between the sequencer, count memory and count unit.
// No dependencies.
package tmb_pkg;

   localparam int COUNT_W = 16;
   localparam int MODE_W = 2;
   localparam int SLOT_W = 4;
   localparam int KIND_W = 2;

   localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
   localparam logic [MODE_W-1:0] MODE_START = 2'd1;
   localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RELOAD = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DONE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

   localparam int MAX_RESULTS = 16;
   localparam int RESULT_CNT_W = 5;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [SLOT_W-1:0]  slot;
      logic [COUNT_W-1:0] period;
   } req_item_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot_out;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic               we_remaining;
      logic               we_period;
      logic [COUNT_W-1:0] remaining;
      logic [COUNT_W-1:0] period;
   } ram_write_type;

   typedef struct packed {
      logic               reload;
      logic [COUNT_W-1:0] remaining;
      logic [COUNT_W-1:0] period;
   } count_cmd_type;

   typedef struct packed {
      logic [COUNT_W-1:0] next_count;
      logic               reached_zero;
   } count_result_type;

endpackage

>>> rtl/tmb_count_ram.sv
// Count memory of the timer bank: remaining count and reload period per slot.
// One write address and one read address per cycle, registered read data.
// Depends on tmb_pkg.
module tmb_count_ram #(
   parameter int NUM_SLOTS = 16,
   parameter int IDX_W = 4
) (
   input  logic                        clock,
   input  logic [IDX_W-1:0]            wr_addr,
   input  tmb_pkg::ram_write_type      wr,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [tmb_pkg::COUNT_W-1:0] rd_remaining,
   output logic [tmb_pkg::COUNT_W-1:0] rd_period
);

   logic [tmb_pkg::COUNT_W-1:0] remaining_mem [NUM_SLOTS];
   logic [tmb_pkg::COUNT_W-1:0] period_mem [NUM_SLOTS];
   logic [tmb_pkg::COUNT_W-1:0] rd_remaining_ff;
   logic [tmb_pkg::COUNT_W-1:0] rd_period_ff;

   always_ff @(posedge clock) begin
      if (wr.we_remaining) begin
         remaining_mem[wr_addr] <= wr.remaining;
      end
      if (wr.we_period) begin
         period_mem[wr_addr] <= wr.period;
      end
      rd_remaining_ff <= remaining_mem[rd_addr];
      rd_period_ff <= period_mem[rd_addr];
   end

   assign rd_remaining = rd_remaining_ff;
   assign rd_period = rd_period_ff;

endmodule

>>> rtl/tmb_count_unit.sv
// Shared count unit of the timer bank: decrements a remaining count modulo 2^16
// and flags zero, or passes the reload period through. Depends on tmb_pkg.
module tmb_count_unit (
   input  tmb_pkg::count_cmd_type    cmd,
   output tmb_pkg::count_result_type res
);

   logic [tmb_pkg::COUNT_W-1:0] decremented;

   assign decremented = cmd.remaining - tmb_pkg::COUNT_W'(1);

   always_comb begin
      if (cmd.reload) begin
         res.next_count = cmd.period;
         res.reached_zero = 1'b0;
      end else begin
         res.next_count = decremented;
         res.reached_zero = (decremented == '0);
      end
   end

endmodule

>>> rtl/multi_slot_one_shot_timer_bank.sv
// Top level of the one-shot timer bank: command sequencer, slot active flags and
// result register. Depends on tmb_pkg, tmb_count_ram and tmb_count_unit.
//
// An item (mode, slot, period) is taken on a clock edge where start is high and busy
// is low. Results appear on rsp_item for one cycle each, marked by rsp_strobe; the
// receiver cannot stall them, and the final result of an item has last set.
// Start and stop finish at once: the result follows in the cycle after the item and busy
// stays low, so one of these can be taken every cycle. A reload of an inactive or
// out-of-range slot is ignored at once as well; otherwise it reads the period, writes it
// back as the remaining count and holds busy high for one cycle; its result is registered
// after the read. A tick walks the count memory one slot per cycle through its single
// read port and the shared decrement unit, then drains its last result. Results come out
// during the walk and in its final cycle, in ascending slot order, at most 16 per tick.
// Reset clears all active flags and returns the sequencer to idle; the count memory
// is not cleared, since a slot's count is only used while a start has made it active.
module multi_slot_one_shot_timer_bank #(
   parameter int NUM_SLOTS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tmb_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output tmb_pkg::rsp_item_type rsp_item
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int WIDE_W = IDX_W + tmb_pkg::SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RELOAD = 2'd1;
   localparam logic [1:0] ST_TICK = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   function automatic logic [tmb_pkg::SLOT_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
      logic [WIDE_W-1:0] wide;
      wide = {{tmb_pkg::SLOT_W{1'b0}}, idx};
      return wide[tmb_pkg::SLOT_W-1:0];
   endfunction

   logic [1:0]                          state_ff, state_in;
   logic [IDX_W-1:0]                    rd_idx_ff, rd_idx_in;
   logic                                rd_go_ff, rd_go_in;
   logic [IDX_W-1:0]                    st_idx_ff, st_idx_in;
   logic                                st_valid_ff, st_valid_in;
   logic [IDX_W-1:0]                    pend_idx_ff, pend_idx_in;
   logic                                pend_valid_ff, pend_valid_in;
   logic [tmb_pkg::RESULT_CNT_W-1:0]    cnt_ff, cnt_in;
   logic [IDX_W-1:0]                    cmd_idx_ff, cmd_idx_in;
   logic [NUM_SLOTS-1:0]                active_ff, active_in;
   logic                                rsp_strobe_ff, rsp_strobe_in;
   tmb_pkg::rsp_item_type               rsp_item_ff, rsp_item_in;

   logic [WIDE_W-1:0]                   cmd_wide;
   logic [IDX_W-1:0]                    cmd_idx;
   logic                                cmd_in_range;
   logic                                accept;
   logic [IDX_W-1:0]                    wr_addr;
   logic [IDX_W-1:0]                    rd_addr;
   tmb_pkg::ram_write_type              ram_wr;
   logic [tmb_pkg::COUNT_W-1:0]         rd_remaining;
   logic [tmb_pkg::COUNT_W-1:0]         rd_period;
   tmb_pkg::count_cmd_type              count_cmd;
   tmb_pkg::count_result_type           count_res;

   assign cmd_wide = {{IDX_W{1'b0}}, req_item.slot};
   assign cmd_idx = cmd_wide[IDX_W-1:0];
   assign cmd_in_range = (cmd_wide < WIDE_W'(NUM_SLOTS));
   assign accept = start && (state_ff == ST_IDLE);

   tmb_count_ram #(
      .NUM_SLOTS(NUM_SLOTS),
      .IDX_W(IDX_W)
   ) u_count_ram (
      .clock(clock),
      .wr_addr(wr_addr),
      .wr(ram_wr),
      .rd_addr(rd_addr),
      .rd_remaining(rd_remaining),
      .rd_period(rd_period)
   );

   tmb_count_unit u_count_unit (
      .cmd(count_cmd),
      .res(count_res)
   );

   always_comb begin
      state_in = state_ff;
      rd_idx_in = rd_idx_ff;
      rd_go_in = rd_go_ff;
      st_idx_in = st_idx_ff;
      st_valid_in = st_valid_ff;
      pend_idx_in = pend_idx_ff;
      pend_valid_in = pend_valid_ff;
      cnt_in = cnt_ff;
      cmd_idx_in = cmd_idx_ff;
      active_in = active_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      ram_wr = '0;
      wr_addr = cmd_idx;
      rd_addr = cmd_idx;
      count_cmd.reload = 1'b0;
      count_cmd.remaining = rd_remaining;
      count_cmd.period = rd_period;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_item_in.kind = tmb_pkg::KIND_IGNORED;
               rsp_item_in.slot_out = req_item.slot;
               rsp_item_in.last = 1'b1;
               unique case (req_item.mode)
                  tmb_pkg::MODE_TICK: begin
                     state_in = ST_TICK;
                     rd_idx_in = '0;
                     rd_go_in = 1'b1;
                     st_valid_in = 1'b0;
                     pend_valid_in = 1'b0;
                     cnt_in = '0;
                  end
                  tmb_pkg::MODE_START: begin
                     rsp_strobe_in = 1'b1;
                     if (cmd_in_range && !active_ff[cmd_idx]) begin
                        ram_wr.we_remaining = 1'b1;
                        ram_wr.we_period = 1'b1;
                        ram_wr.remaining = req_item.period;
                        ram_wr.period = req_item.period;
                        active_in[cmd_idx] = 1'b1;
                        rsp_item_in.kind = tmb_pkg::KIND_DONE;
                     end
                  end
                  tmb_pkg::MODE_STOP: begin
                     rsp_strobe_in = 1'b1;
                     if (cmd_in_range && active_ff[cmd_idx]) begin
                        active_in[cmd_idx] = 1'b0;
                        rsp_item_in.kind = tmb_pkg::KIND_DONE;
                     end
                  end
                  tmb_pkg::MODE_RELOAD: begin
                     if (cmd_in_range && active_ff[cmd_idx]) begin
                        state_in = ST_RELOAD;
                        cmd_idx_in = cmd_idx;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_RELOAD: begin
            count_cmd.reload = 1'b1;
            wr_addr = cmd_idx_ff;
            ram_wr.we_remaining = 1'b1;
            ram_wr.remaining = count_res.next_count;
            rsp_strobe_in = 1'b1;
            rsp_item_in.kind = tmb_pkg::KIND_DONE;
            state_in = ST_IDLE;
         end
         ST_TICK: begin
            rd_addr = rd_idx_ff;
            st_valid_in = rd_go_ff;
            st_idx_in = rd_idx_ff;
            if (rd_go_ff) begin
               if (rd_idx_ff == LAST_IDX) begin
                  rd_go_in = 1'b0;
               end else begin
                  rd_idx_in = rd_idx_ff + IDX_W'(1);
               end
            end
            if (st_valid_ff) begin
               wr_addr = st_idx_ff;
               if (active_ff[st_idx_ff]) begin
                  ram_wr.we_remaining = 1'b1;
                  ram_wr.remaining = count_res.next_count;
                  if (count_res.reached_zero) begin
                     active_in[st_idx_ff] = 1'b0;
                     if (cnt_ff < tmb_pkg::RESULT_CNT_W'(tmb_pkg::MAX_RESULTS)) begin
                        cnt_in = cnt_ff + tmb_pkg::RESULT_CNT_W'(1);
                        pend_valid_in = 1'b1;
                        pend_idx_in = st_idx_ff;
                        if (pend_valid_ff) begin
                           rsp_strobe_in = 1'b1;
                           rsp_item_in.kind = tmb_pkg::KIND_EXPIRED;
                           rsp_item_in.slot_out = slot_of(pend_idx_ff);
                           rsp_item_in.last = 1'b0;
                        end
                     end
                  end
               end
               if (st_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            rsp_item_in.last = 1'b1;
            if (pend_valid_ff) begin
               rsp_item_in.kind = tmb_pkg::KIND_EXPIRED;
               rsp_item_in.slot_out = slot_of(pend_idx_ff);
            end else begin
               rsp_item_in.kind = tmb_pkg::KIND_DONE;
               rsp_item_in.slot_out = '0;
            end
            pend_valid_in = 1'b0;
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_go_ff <= 1'b0;
         st_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         cnt_ff <= '0;
         active_ff <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_go_ff <= rd_go_in;
         st_valid_ff <= st_valid_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff <= cnt_in;
         active_ff <= active_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      rd_idx_ff <= rd_idx_in;
      st_idx_ff <= st_idx_in;
      pend_idx_ff <= pend_idx_in;
      cmd_idx_ff <= cmd_idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item = rsp_item_ff;

`ifndef SYNTHESIS
   a_not_last_is_expiry: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.last |-> rsp_item.kind == tmb_pkg::KIND_EXPIRED)
      else $error("non-final result is not an expiry");

   a_start_stop_result: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_item.mode == tmb_pkg::MODE_START ||
                         req_item.mode == tmb_pkg::MODE_STOP)
      |=> rsp_strobe && rsp_item.last)
      else $error("start or stop gave no final result in the next cycle");

   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_item.mode == tmb_pkg::MODE_TICK |=> busy && !rsp_strobe)
      else $error("tick did not enter the walk");

   a_finish_closes_tick: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH |=> rsp_strobe && rsp_item.last && !busy)
      else $error("tick walk ended without a final result");

   a_result_cap: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= tmb_pkg::RESULT_CNT_W'(tmb_pkg::MAX_RESULTS))
      else $error("expiry count exceeds the result limit");
`endif

endmodule

>>> tb/tb_multi_slot_one_shot_timer_bank.sv
// Self-checking testbench for the one-shot timer bank: a directed table followed by
// random command traffic, results checked against table rows or a cycle-free predictor.
// Depends on tmb_pkg and multi_slot_one_shot_timer_bank.
module tb_multi_slot_one_shot_timer_bank;

   localparam int NUM_SLOTS = 16;
   localparam int RANDOM_ITEMS = 320;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      tmb_pkg::req_item_type item;
      bit                    typed;
      tmb_pkg::rsp_item_type want;
   } directed_row_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   tmb_pkg::req_item_type req_item = '0;
   logic                  rsp_strobe;
   tmb_pkg::rsp_item_type rsp_item;

   logic                  row_typed = 1'b0;
   tmb_pkg::rsp_item_type row_want = '0;

   logic [tmb_pkg::COUNT_W-1:0] model_remaining [NUM_SLOTS];
   logic [tmb_pkg::COUNT_W-1:0] model_period [NUM_SLOTS];
   logic                        model_active [NUM_SLOTS];

   tmb_pkg::rsp_item_type expected_results [$];
   tmb_pkg::rsp_item_type step_results [$];
   directed_row_type      directed_rows [$];
   int                    mismatch_count = 0;

   multi_slot_one_shot_timer_bank #(.NUM_SLOTS(NUM_SLOTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic void timer_bank_predict(input tmb_pkg::req_item_type it);
      tmb_pkg::rsp_item_type r;
      logic [tmb_pkg::KIND_W-1:0] kind;
      step_results.delete();
      if (it.mode == tmb_pkg::MODE_TICK) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            if (model_active[i]) begin
               model_remaining[i] = model_remaining[i] - 16'd1;
               if (model_remaining[i] == '0) begin
                  model_active[i] = 1'b0;
                  r.kind = tmb_pkg::KIND_EXPIRED;
                  r.slot_out = i[tmb_pkg::SLOT_W-1:0];
                  r.last = 1'b0;
                  step_results.push_back(r);
               end
            end
         end
         if (step_results.size() == 0) begin
            r.kind = tmb_pkg::KIND_DONE;
            r.slot_out = '0;
            r.last = 1'b1;
            step_results.push_back(r);
         end else begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
         end
      end else begin
         kind = tmb_pkg::KIND_IGNORED;
         if (int'(it.slot) < NUM_SLOTS) begin
            case (it.mode)
               tmb_pkg::MODE_START: begin
                  if (!model_active[it.slot]) begin
                     model_remaining[it.slot] = it.period;
                     model_period[it.slot] = it.period;
                     model_active[it.slot] = 1'b1;
                     kind = tmb_pkg::KIND_DONE;
                  end
               end
               tmb_pkg::MODE_STOP: begin
                  if (model_active[it.slot]) begin
                     model_active[it.slot] = 1'b0;
                     kind = tmb_pkg::KIND_DONE;
                  end
               end
               default: begin
                  if (model_active[it.slot]) begin
                     model_remaining[it.slot] = model_period[it.slot];
                     kind = tmb_pkg::KIND_DONE;
                  end
               end
            endcase
         end
         r.kind = kind;
         r.slot_out = it.slot;
         r.last = 1'b1;
         step_results.push_back(r);
      end
   endfunction

   always @(posedge clock) begin
      tmb_pkg::rsp_item_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result: kind %0d slot %0d last %0d",
                     rsp_item.kind, rsp_item.slot_out, rsp_item.last);
            end else begin
               want = expected_results.pop_front();
               if (rsp_item.kind !== want.kind || rsp_item.slot_out !== want.slot_out ||
                     rsp_item.last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("result mismatch: expected kind %0d slot %0d last %0d, %s",
                        want.kind, want.slot_out, want.last,
                        $sformatf("got kind %0d slot %0d last %0d",
                           rsp_item.kind, rsp_item.slot_out, rsp_item.last));
               end
            end
         end
         if (start && !busy) begin
            timer_bank_predict(req_item);
            if (row_typed)
               expected_results.push_back(row_want);
            else
               foreach (step_results[i])
                  expected_results.push_back(step_results[i]);
         end
      end
   end

   task automatic send_item(input tmb_pkg::req_item_type it, input bit typed,
         input tmb_pkg::rsp_item_type want);
      req_item <= it;
      row_typed <= typed;
      row_want <= want;
      start <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   function automatic tmb_pkg::req_item_type make_item(
         input logic [tmb_pkg::MODE_W-1:0] mode, input int slot, input int period);
      tmb_pkg::req_item_type it;
      it.mode = mode;
      it.slot = slot[tmb_pkg::SLOT_W-1:0];
      it.period = period[tmb_pkg::COUNT_W-1:0];
      return it;
   endfunction

   function automatic void add_row(input logic [tmb_pkg::MODE_W-1:0] mode, input int slot,
         input int period, input bit typed, input logic [tmb_pkg::KIND_W-1:0] kind);
      directed_row_type row;
      row.item = make_item(mode, slot, period);
      row.typed = typed;
      row.want.kind = kind;
      row.want.slot_out = (mode == tmb_pkg::MODE_TICK) ? '0 : row.item.slot;
      row.want.last = 1'b1;
      directed_rows.push_back(row);
   endfunction

   function automatic tmb_pkg::req_item_type random_item();
      int pick;
      tmb_pkg::req_item_type it;
      pick = $urandom_range(0, 99);
      it.slot = tmb_pkg::SLOT_W'($urandom_range(0, 15));
      it.period = tmb_pkg::COUNT_W'($urandom);
      if (pick < 22)
         it.mode = tmb_pkg::MODE_TICK;
      else if (pick < 55) begin
         it.mode = tmb_pkg::MODE_START;
         it.period = tmb_pkg::COUNT_W'($urandom_range(0, 6));
      end else if (pick < 62)
         it.mode = tmb_pkg::MODE_START;
      else if (pick < 78)
         it.mode = tmb_pkg::MODE_STOP;
      else
         it.mode = tmb_pkg::MODE_RELOAD;
      return it;
   endfunction

   // Frees every slot, arms all of them for one tick and fires the tick, so that one
   // item yields the largest burst of expirations.
   task automatic fill_all_slots();
      for (int s = 0; s < NUM_SLOTS; s++)
         send_item(make_item(tmb_pkg::MODE_STOP, s, $urandom), 1'b0, '0);
      for (int s = 0; s < NUM_SLOTS; s++)
         send_item(make_item(tmb_pkg::MODE_START, s, 1), 1'b0, '0);
      send_item(make_item(tmb_pkg::MODE_TICK, $urandom_range(0, 15), $urandom), 1'b0, '0);
   endtask

   initial begin
      bit quiet;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         model_remaining[s] = '0;
         model_period[s] = '0;
         model_active[s] = 1'b0;
      end

      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_STOP,    3, 0,       1'b1, tmb_pkg::KIND_IGNORED);
      add_row(tmb_pkg::MODE_RELOAD, 15, 16'hFFFF, 1'b1, tmb_pkg::KIND_IGNORED);
      add_row(tmb_pkg::MODE_START,   0, 1,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_START,   0, 16'hFFFF, 1'b1, tmb_pkg::KIND_IGNORED);
      add_row(tmb_pkg::MODE_START,  15, 16'hFFFF, 1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_START,   7, 0,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_START,   3, 1,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_RELOAD, 15, 0,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_STOP,    7, 0,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_STOP,    7, 0,       1'b1, tmb_pkg::KIND_IGNORED);
      add_row(tmb_pkg::MODE_START,   5, 2,       1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_RELOAD,  5, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_RELOAD,  5, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,    0, 0,       1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_RELOAD,  5, 0,       1'b1, tmb_pkg::KIND_IGNORED);
      add_row(tmb_pkg::MODE_START,  10, 16'hAAAA, 1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_START,   9, 16'h5555, 1'b1, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_TICK,   15, 16'hFFFF, 1'b0, tmb_pkg::KIND_DONE);
      add_row(tmb_pkg::MODE_STOP,   15, 0,       1'b1, tmb_pkg::KIND_DONE);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
         if ($urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
      end

      fill_all_slots();

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == 150)
            fill_all_slots();
         if (k == 200) begin
            start <= 1'b0;
            @(posedge clock);
            while (expected_results.size() != 0) @(posedge clock);
         end
         send_item(random_item(), 1'b0, '0);
         quiet = (k >= 100 && k < 160) || (k >= RANDOM_ITEMS - 60);
         if (!quiet && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 9));
      end

      start <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (NUM_SLOTS + 4) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb_multi_slot_one_shot_timer_bank passed");
      else
         $display("tb_multi_slot_one_shot_timer_bank failed");
      $finish;
   end

   initial begin
      #1000000;
      $display("tb_multi_slot_one_shot_timer_bank failed");
      $finish;
   end

endmodule
